// ===== src/bsc_pkg.sv =====
// Shared types and constants of the banker's safety check block.
package bsc_pkg;

  localparam int MAX_PROCS = 16;
  localparam int IDX_W     = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int CNT_W     = $clog2(MAX_PROCS + 1);
  localparam int ITEM_W    = 8;
  localparam int NEED_W    = ITEM_W + 1;
  localparam int TOT_W     = 12;
  localparam int SUM_W     = ITEM_W + CNT_W;
  localparam int WORK_W    = ((SUM_W > TOT_W) ? SUM_W : TOT_W) + 2;
  localparam int PIDX_W    = 4;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_TOTAL_A = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_TOTAL_B = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_TOTAL_C = CFG_IDX_W'(2);

  localparam logic [TOT_W-1:0] TOTAL_A_RST = TOT_W'(10);
  localparam logic [TOT_W-1:0] TOTAL_B_RST = TOT_W'(5);
  localparam logic [TOT_W-1:0] TOTAL_C_RST = TOT_W'(7);

  typedef struct packed {
    logic [ITEM_W-1:0] alloc_a;
    logic [ITEM_W-1:0] alloc_b;
    logic [ITEM_W-1:0] alloc_c;
    logic [ITEM_W-1:0] claim_a;
    logic [ITEM_W-1:0] claim_b;
    logic [ITEM_W-1:0] claim_c;
    logic              last;
  } bsc_in_t;

  typedef struct packed {
    logic [PIDX_W-1:0] proc_index;
    logic              safe;
    logic              seq_end;
  } bsc_out_t;

  typedef struct packed {
    logic [ITEM_W-1:0]        alloc_a;
    logic [ITEM_W-1:0]        alloc_b;
    logic [ITEM_W-1:0]        alloc_c;
    logic signed [NEED_W-1:0] need_a;
    logic signed [NEED_W-1:0] need_b;
    logic signed [NEED_W-1:0] need_c;
  } bsc_entry_t;

  typedef struct packed {
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
  } bsc_mem_ctl_t;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_INIT,
    ST_READ,
    ST_EVAL,
    ST_EMIT
  } bsc_state_t;

endpackage

// ===== src/bsc_store.sv =====
// Process table memory: allocation and signed need per process, registered read.
module bsc_store (
  input  logic                  clk,
  input  bsc_pkg::bsc_mem_ctl_t ctl,
  input  bsc_pkg::bsc_in_t      wr_data,
  output bsc_pkg::bsc_entry_t   rd_data
);
  import bsc_pkg::*;

  bsc_entry_t mem_r [MAX_PROCS];
  bsc_entry_t rd_data_r;
  bsc_entry_t wr_entry;

  always_comb begin
    wr_entry.alloc_a = wr_data.alloc_a;
    wr_entry.alloc_b = wr_data.alloc_b;
    wr_entry.alloc_c = wr_data.alloc_c;
    wr_entry.need_a  = $signed({1'b0, wr_data.claim_a}) - $signed({1'b0, wr_data.alloc_a});
    wr_entry.need_b  = $signed({1'b0, wr_data.claim_b}) - $signed({1'b0, wr_data.alloc_b});
    wr_entry.need_c  = $signed({1'b0, wr_data.claim_c}) - $signed({1'b0, wr_data.alloc_c});
  end

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem_r[ctl.wr_addr] <= wr_entry;
    end
    if (ctl.rd_en) begin
      rd_data_r <= mem_r[ctl.rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== src/bankers_safety_check_core.sv =====
// Top level of the banker's safety check: process loading, safety passes, sequence output.
//
//   channel | direction | handshake           | payload
//   cfg     | in        | cfg_we              | cfg_index, cfg_wdata (totals A, B, C)
//   in      | in        | in_valid / in_stall | bsc_in_t, one process per request
//   out     | out       | out_valid/out_stall | bsc_out_t, one sequence entry per request
//
// Loading takes one request per cycle; a request beyond MAX_PROCS is dropped but its
// last mark still starts the check. The check runs a setup step, then on each pass it
// skips each finished process and does a table read and a compare on each open one,
// for at most n passes over n processes. The result sequence follows at one per cycle
// while out_stall is low. Input stalls from the last request until the final result is
// taken. Reset is synchronous; the process table needs no clearing.
module bankers_safety_check_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [bsc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bsc_pkg::TOT_W-1:0]     cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  bsc_pkg::bsc_in_t              in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output bsc_pkg::bsc_out_t             out_data
);
  import bsc_pkg::*;

  bsc_state_t state_r, state_nxt;

  logic [TOT_W-1:0] total_a_r, total_b_r, total_c_r;
  logic [SUM_W-1:0] sum_a_r, sum_b_r, sum_c_r;
  logic [SUM_W-1:0] sum_a_nxt, sum_b_nxt, sum_c_nxt;
  logic signed [WORK_W-1:0] work_a_r, work_b_r, work_c_r;
  logic signed [WORK_W-1:0] work_a_nxt, work_b_nxt, work_c_nxt;
  logic [MAX_PROCS-1:0] fin_r, fin_nxt;
  logic [CNT_W-1:0] proc_cnt_r, proc_cnt_nxt;
  logic [CNT_W-1:0] acc_cnt_r, acc_cnt_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [IDX_W-1:0] out_ptr_r, out_ptr_nxt;
  logic found_r, found_nxt;
  logic safe_r, safe_nxt;
  logic [IDX_W-1:0] order_r [MAX_PROCS];

  bsc_mem_ctl_t mem_ctl;
  bsc_entry_t   rd_entry;

  logic in_acc, out_acc, has_room;
  logic signed [WORK_W-1:0] need_a_x, need_b_x, need_c_x;
  logic fits, accept_now, pass_end, found_after, all_done;
  logic [CNT_W-1:0] acc_after;

  bsc_store u_store (
    .clk     (clk),
    .ctl     (mem_ctl),
    .wr_data (in_data),
    .rd_data (rd_entry)
  );

  assign in_acc   = in_valid && !in_stall;
  assign out_acc  = out_valid && !out_stall;
  assign has_room = proc_cnt_r < CNT_W'(MAX_PROCS);

  assign need_a_x = WORK_W'(rd_entry.need_a);
  assign need_b_x = WORK_W'(rd_entry.need_b);
  assign need_c_x = WORK_W'(rd_entry.need_c);

  assign fits        = (need_a_x <= work_a_r) && (need_b_x <= work_b_r) &&
                       (need_c_x <= work_c_r);
  assign accept_now  = (state_r == ST_EVAL) && fits;
  assign acc_after   = acc_cnt_r + CNT_W'(accept_now);
  assign found_after = found_r || accept_now;
  assign pass_end    = (CNT_W'(idx_r) + CNT_W'(1)) == proc_cnt_r;
  assign all_done    = acc_after == proc_cnt_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_LOAD: begin
        if (in_acc && in_data.last) begin
          state_nxt = ST_INIT;
        end
      end
      ST_INIT: begin
        state_nxt = ST_READ;
      end
      ST_READ: begin
        if (!fin_r[idx_r]) begin
          state_nxt = ST_EVAL;
        end else if (pass_end && (all_done || !found_after)) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EVAL: begin
        if (pass_end && (all_done || !found_after)) begin
          state_nxt = ST_EMIT;
        end else begin
          state_nxt = ST_READ;
        end
      end
      ST_EMIT: begin
        if (out_acc && out_data.seq_end) begin
          state_nxt = ST_LOAD;
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  always_comb begin
    in_stall            = state_r != ST_LOAD;
    out_valid           = state_r == ST_EMIT;
    out_data.safe       = safe_r;
    out_data.proc_index = safe_r ? PIDX_W'(order_r[out_ptr_r]) : '0;
    out_data.seq_end    = !safe_r || ((CNT_W'(out_ptr_r) + CNT_W'(1)) == proc_cnt_r);
    mem_ctl.wr_en       = in_acc && has_room;
    mem_ctl.wr_addr     = proc_cnt_r[IDX_W-1:0];
    mem_ctl.rd_en       = (state_r == ST_READ) && !fin_r[idx_r];
    mem_ctl.rd_addr     = idx_r;
  end

  always_comb begin
    sum_a_nxt    = sum_a_r;
    sum_b_nxt    = sum_b_r;
    sum_c_nxt    = sum_c_r;
    work_a_nxt   = work_a_r;
    work_b_nxt   = work_b_r;
    work_c_nxt   = work_c_r;
    fin_nxt      = fin_r;
    proc_cnt_nxt = proc_cnt_r;
    acc_cnt_nxt  = acc_cnt_r;
    idx_nxt      = idx_r;
    out_ptr_nxt  = out_ptr_r;
    found_nxt    = found_r;
    safe_nxt     = safe_r;
    case (state_r)
      ST_LOAD: begin
        if (in_acc && has_room) begin
          sum_a_nxt    = sum_a_r + SUM_W'(in_data.alloc_a);
          sum_b_nxt    = sum_b_r + SUM_W'(in_data.alloc_b);
          sum_c_nxt    = sum_c_r + SUM_W'(in_data.alloc_c);
          proc_cnt_nxt = proc_cnt_r + CNT_W'(1);
        end
      end
      ST_INIT: begin
        work_a_nxt  = $signed(WORK_W'(total_a_r)) - $signed(WORK_W'(sum_a_r));
        work_b_nxt  = $signed(WORK_W'(total_b_r)) - $signed(WORK_W'(sum_b_r));
        work_c_nxt  = $signed(WORK_W'(total_c_r)) - $signed(WORK_W'(sum_c_r));
        sum_a_nxt   = '0;
        sum_b_nxt   = '0;
        sum_c_nxt   = '0;
        fin_nxt     = '0;
        acc_cnt_nxt = '0;
        idx_nxt     = '0;
        found_nxt   = 1'b0;
      end
      ST_READ, ST_EVAL: begin
        if (accept_now) begin
          work_a_nxt     = work_a_r + $signed(WORK_W'(rd_entry.alloc_a));
          work_b_nxt     = work_b_r + $signed(WORK_W'(rd_entry.alloc_b));
          work_c_nxt     = work_c_r + $signed(WORK_W'(rd_entry.alloc_c));
          fin_nxt[idx_r] = 1'b1;
          acc_cnt_nxt    = acc_after;
          found_nxt      = 1'b1;
        end
        if ((state_r == ST_EVAL) || fin_r[idx_r]) begin
          if (pass_end) begin
            idx_nxt     = '0;
            found_nxt   = 1'b0;
            safe_nxt    = all_done;
            out_ptr_nxt = '0;
          end else begin
            idx_nxt = idx_r + IDX_W'(1);
          end
        end
      end
      ST_EMIT: begin
        if (out_acc) begin
          out_ptr_nxt = out_ptr_r + IDX_W'(1);
          if (out_data.seq_end) begin
            proc_cnt_nxt = '0;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_LOAD;
      total_a_r  <= TOTAL_A_RST;
      total_b_r  <= TOTAL_B_RST;
      total_c_r  <= TOTAL_C_RST;
      sum_a_r    <= '0;
      sum_b_r    <= '0;
      sum_c_r    <= '0;
      work_a_r   <= '0;
      work_b_r   <= '0;
      work_c_r   <= '0;
      fin_r      <= '0;
      proc_cnt_r <= '0;
      acc_cnt_r  <= '0;
      idx_r      <= '0;
      out_ptr_r  <= '0;
      found_r    <= 1'b0;
      safe_r     <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      sum_a_r    <= sum_a_nxt;
      sum_b_r    <= sum_b_nxt;
      sum_c_r    <= sum_c_nxt;
      work_a_r   <= work_a_nxt;
      work_b_r   <= work_b_nxt;
      work_c_r   <= work_c_nxt;
      fin_r      <= fin_nxt;
      proc_cnt_r <= proc_cnt_nxt;
      acc_cnt_r  <= acc_cnt_nxt;
      idx_r      <= idx_nxt;
      out_ptr_r  <= out_ptr_nxt;
      found_r    <= found_nxt;
      safe_r     <= safe_nxt;
      if (cfg_we) begin
        case (cfg_index)
          REG_TOTAL_A: total_a_r <= cfg_wdata;
          REG_TOTAL_B: total_b_r <= cfg_wdata;
          REG_TOTAL_C: total_c_r <= cfg_wdata;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept_now) begin
      order_r[acc_cnt_r[IDX_W-1:0]] <= idx_r;
    end
  end

endmodule

// ===== src/bsc_checker.sv =====
// Port-level assertions for the banker's safety check block, bound to the top level.
module bsc_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input bsc_pkg::bsc_in_t  in_data,
  input logic              out_valid,
  input logic              out_stall,
  input bsc_pkg::bsc_out_t out_data
);
  import bsc_pkg::*;

  a_no_load_while_emit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input request taken while results pending");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("stalled result request changed");

  a_unsafe_single: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.safe) |-> (out_data.seq_end && (out_data.proc_index == '0)))
    else $error("unsafe result is not a single terminal request");

  a_end_drops_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && out_data.seq_end) |=> !out_valid)
    else $error("result valid after final request");

  a_last_holds_input: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_data.last) |=> in_stall)
    else $error("input not held after last request");

endmodule

bind bankers_safety_check_core bsc_checker u_bsc_checker (.*);
